// ----- hw/rtl/paged_monochrome_framebuffer_defines.svh -----
`ifndef PAGED_MONOCHROME_FRAMEBUFFER_DEFINES_SVH
`define PAGED_MONOCHROME_FRAMEBUFFER_DEFINES_SVH

// same-cycle implication check, idle during reset
`define PMFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmfb implication check failed");

// next-cycle implication check, idle during reset
`define PMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmfb next-cycle check failed");

`endif

// ----- hw/rtl/pmfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pmfb_pkg;

    // display geometry
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int ROWS_PER_PAGE  = 8;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int STORE_BYTES    = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BIT_ONE   = 8'h01;
    localparam logic [7:0] FULL_MASK = 8'hFF;

    // action codes
    localparam logic [2:0] ACT_WRITE_PIXEL  = 3'd0;
    localparam logic [2:0] ACT_READ_PIXEL   = 3'd1;
    localparam logic [2:0] ACT_FILL_ALL     = 3'd2;
    localparam logic [2:0] ACT_BEGIN_BITMAP = 3'd3;
    localparam logic [2:0] ACT_BITMAP_BYTE  = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              accepted;
        logic [2:0]        bit_sel;
        logic              second;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [7:0]        mask0;
        logic [7:0]        mask1;
        logic [7:0]        data0;
        logic [7:0]        data1;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS0,
        ST_ACCESS1,
        ST_FILL,
        ST_HOLD
    } back_state_t;

    // byte address of a page and column
    function automatic logic [ADDR_W-1:0] store_addr(input logic [5:0] page,
                                                     input logic [8:0] col);
        logic [15:0] a;
        a = 16'(page) * 16'(DISPLAY_WIDTH) + 16'(col);
        return a[ADDR_W-1:0];
    endfunction

    // bits of a page whose rows lie on the display
    function automatic logic [7:0] page_mask(input logic [5:0] page);
        logic [7:0] m;
        logic [9:0] row;
        for (int b = 0; b < 8; b++) begin
            row  = {1'b0, page, 3'(b)};
            m[b] = row < 10'(DISPLAY_HEIGHT);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pmfb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pmfb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmfb_front import pmfb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hold,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [2:0]         action,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic               pixel_value,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         bitmap_width,
    input  logic [7:0]         bitmap_height,
    input  logic               q_full,
    output logic               push,
    output cmd_t               cmd
);

    // bitmap cursor state
    logic       active_reg, active_next;
    logic [7:0] left_reg, left_next;
    logic [8:0] right_reg, right_next;
    logic [8:0] bottom_reg, bottom_next;
    logic [8:0] col_reg, col_next;
    logic [8:0] row_reg, row_next;

    logic        pix_on;
    logic [7:0]  pix_mask;
    logic [9:0]  x_sum;
    logic [9:0]  y_sum;
    logic        rect_ok;
    logic [5:0]  page0;
    logic [5:0]  page1;
    logic [15:0] data_wide;
    logic [15:0] mask_wide;
    logic [7:0]  mask1;
    logic [8:0]  col_inc;
    logic [8:0]  row_inc;

    assign item_ready = !q_full && !hold;
    assign push       = item_valid && item_ready;

    // pixel and rectangle checks
    always_comb
    begin
        pix_on   = !x[15] && (x[14:0] < 15'(DISPLAY_WIDTH))
                   && !y[15] && (y[14:0] < 15'(DISPLAY_HEIGHT));
        pix_mask = BIT_ONE << y[2:0];
        x_sum    = 10'(x[8:0]) + 10'(bitmap_width);
        y_sum    = 10'(y[8:0]) + 10'(bitmap_height);
        rect_ok  = pix_on && (x_sum <= 10'(DISPLAY_WIDTH))
                   && (y_sum <= 10'(DISPLAY_HEIGHT));
    end

    // bitmap byte split over up to two pages
    always_comb
    begin
        page0     = row_reg[8:3];
        page1     = page0 + 6'd1;
        data_wide = {8'h00, data_byte} << row_reg[2:0];
        mask_wide = {8'h00, FULL_MASK} << row_reg[2:0];
        mask1     = mask_wide[15:8] & page_mask(page1);
        col_inc   = col_reg + 9'd1;
        row_inc   = row_reg + 9'(ROWS_PER_PAGE);
    end

    // action decode
    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.bit_sel  = y[2:0];
        cmd.addr0    = store_addr(y[8:3], x[8:0]);
        cmd.addr1    = store_addr(page1, col_reg);
        cmd.data0    = data_byte;
        active_next  = active_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        bottom_next  = bottom_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        unique case (action)
            ACT_WRITE_PIXEL:
            begin
                if (pix_on)
                begin
                    cmd.op       = OP_WRITE;
                    cmd.accepted = 1'b1;
                    cmd.mask0    = pix_mask;
                    cmd.data0    = pixel_value ? pix_mask : 8'h00;
                end
            end
            ACT_READ_PIXEL:
            begin
                if (pix_on)
                begin
                    cmd.op       = OP_READ;
                    cmd.accepted = 1'b1;
                end
            end
            ACT_FILL_ALL:
            begin
                cmd.op       = OP_FILL;
                cmd.accepted = 1'b1;
            end
            ACT_BEGIN_BITMAP:
            begin
                if (rect_ok)
                begin
                    cmd.accepted = 1'b1;
                    left_next    = x[7:0];
                    right_next   = x_sum[8:0];
                    bottom_next  = y_sum[8:0];
                    col_next     = x[8:0];
                    row_next     = y[8:0];
                    active_next  = (bitmap_width != 8'd0) && (bitmap_height != 8'd0);
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            ACT_BITMAP_BYTE:
            begin
                if (active_reg)
                begin
                    cmd.op       = OP_WRITE;
                    cmd.accepted = 1'b1;
                    cmd.addr0    = store_addr(page0, col_reg);
                    cmd.mask0    = mask_wide[7:0] & page_mask(page0);
                    cmd.data0    = data_wide[7:0];
                    cmd.mask1    = mask1;
                    cmd.data1    = data_wide[15:8];
                    cmd.second   = |mask1;
                    col_next     = col_inc;
                    if (col_inc >= right_reg)
                    begin
                        col_next = 9'(left_reg);
                        row_next = row_inc;
                        if (row_inc >= bottom_reg)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    // cursor registers advance only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (push)
        begin
            active_reg <= active_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pmfb_cmd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmfb_cmd_queue import pmfb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pmfb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmfb_back import pmfb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t head,
    output logic pop,
    output logic clearing,
    output logic result_valid,
    input  logic result_ready,
    output logic pixel,
    output logic accepted
);

    back_state_t       state_reg, state_next;
    cmd_t              cur_reg;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              hold_pixel_reg;
    logic              hold_acc_reg;
    logic              result_valid_reg, result_valid_next;
    logic              pixel_reg;
    logic              accepted_reg;

    logic              out_free;
    logic              sweep_last;
    logic              sweep_step;
    logic              cur_load;
    logic              direct_load;
    logic              finish;
    logic              fin_pixel;
    logic              load;
    logic              load_pixel;
    logic              load_acc;
    logic              hold_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;
    logic [7:0]        merged0;
    logic [7:0]        merged1;

    pmfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free   = !result_valid_reg || result_ready;
    assign sweep_last = sweep_reg == ADDR_W'(STORE_BYTES - 1);
    assign clearing   = state_reg == ST_CLEAR;
    assign merged0    = (ram_rd_data & ~cur_reg.mask0) | (cur_reg.data0 & cur_reg.mask0);
    assign merged1    = (ram_rd_data & ~cur_reg.mask1) | (cur_reg.data1 & cur_reg.mask1);

    // state machine outputs
    always_comb
    begin
        pop         = 1'b0;
        cur_load    = 1'b0;
        direct_load = 1'b0;
        finish      = 1'b0;
        fin_pixel   = 1'b0;
        sweep_step  = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = sweep_reg;
        ram_wr_data = 8'h00;
        ram_rd_addr = head.addr0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_step = 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head.op) inside
                        OP_READ, OP_WRITE, OP_FILL:
                        begin
                            pop      = 1'b1;
                            cur_load = 1'b1;
                        end
                        OP_NONE:
                        begin
                            if (out_free)
                            begin
                                pop         = 1'b1;
                                direct_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_ACCESS0:
            begin
                if (cur_reg.op == OP_WRITE)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = cur_reg.addr0;
                    ram_wr_data = merged0;
                end
                if (cur_reg.op == OP_WRITE && cur_reg.second)
                begin
                    ram_rd_addr = cur_reg.addr1;
                end
                else
                begin
                    finish    = 1'b1;
                    fin_pixel = (cur_reg.op == OP_READ) && ram_rd_data[cur_reg.bit_sel];
                end
            end
            ST_ACCESS1:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = cur_reg.addr1;
                ram_wr_data = merged1;
                finish      = 1'b1;
            end
            ST_FILL:
            begin
                ram_we      = 1'b1;
                ram_wr_data = cur_reg.data0;
                sweep_step  = 1'b1;
                finish      = sweep_last;
            end
            ST_HOLD:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cur_load)
                begin
                    state_next = (head.op == OP_FILL) ? ST_FILL : ST_ACCESS0;
                end
            end
            ST_ACCESS0:
            begin
                if (finish)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
                else
                begin
                    state_next = ST_ACCESS1;
                end
            end
            ST_ACCESS1:
            begin
                state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_FILL:
            begin
                if (finish)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result selection
    always_comb
    begin
        hold_load  = finish && !out_free;
        load       = 1'b0;
        load_pixel = 1'b0;
        load_acc   = 1'b0;
        if (direct_load)
        begin
            load     = 1'b1;
            load_acc = head.accepted;
        end
        else if (finish && out_free)
        begin
            load       = 1'b1;
            load_pixel = fin_pixel;
            load_acc   = cur_reg.accepted;
        end
        else if (state_reg == ST_HOLD && out_free)
        begin
            load       = 1'b1;
            load_pixel = hold_pixel_reg;
            load_acc   = hold_acc_reg;
        end
        result_valid_next = load || (result_valid_reg && !result_ready);
    end

    // sweep address for clear and fill
    always_comb
    begin
        sweep_next = sweep_reg;
        if (sweep_step)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= head;
        end
        if (hold_load)
        begin
            hold_pixel_reg <= fin_pixel;
            hold_acc_reg   <= cur_reg.accepted;
        end
        if (load)
        begin
            pixel_reg    <= load_pixel;
            accepted_reg <= load_acc;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel        = pixel_reg;
    assign accepted     = accepted_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/paged_monochrome_framebuffer.sv -----
// Paged monochrome framebuffer, 128 x 64 pixels, eight vertical pixels per byte.
// Item channel: item_valid/item_ready with action, x, y, pixel_value, data_byte,
// bitmap_width and bitmap_height. Result channel: result_valid/result_ready with
// pixel and accepted; every item gives exactly one result beat, in order.
// The front decodes each beat, clips it and runs the bitmap cursor; a two-entry
// command queue feeds the back, which owns the frame store (one write port and
// one registered read port).
// Path through the back: an on-screen pixel write or read and a bitmap byte
// within one page go through ST_ACCESS0 (read, then write back), a bitmap byte
// straddling two pages goes through ST_ACCESS0 and then ST_ACCESS1, begin bitmap,
// clipped pixels, bitmap bytes with no bitmap armed and unused codes are answered
// straight from ST_IDLE, and fill all sweeps the whole store in ST_FILL, one store
// byte per cycle. The back works on one command at a time while the queue keeps
// taking beats.
// After reset every store byte is swept to zero while item_ready is held low.
// When the receiver stalls, the finished result waits in the output register,
// the back holds and the queue keeps taking beats until both entries are full.
`timescale 1ns / 1ps
`default_nettype none

`include "paged_monochrome_framebuffer_defines.svh"

module paged_monochrome_framebuffer import pmfb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [2:0]         action,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic               pixel_value,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         bitmap_width,
    input  logic [7:0]         bitmap_height,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               pixel,
    output logic               accepted
);

    logic clearing;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t front_cmd;
    cmd_t q_head;

    // decode and cursor
    pmfb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (clearing),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .x             (x),
        .y             (y),
        .pixel_value   (pixel_value),
        .data_byte     (data_byte),
        .bitmap_width  (bitmap_width),
        .bitmap_height (bitmap_height),
        .q_full        (q_full),
        .push          (q_push),
        .cmd           (front_cmd)
    );

    // command queue
    pmfb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // store access and result
    pmfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head         (q_head),
        .pop          (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel        (pixel),
        .accepted     (accepted)
    );

    // checks
    `PMFB_ASSERT_IMPLY(a_no_beat_while_clearing, clk, rst_n, clearing, !item_ready)
    `PMFB_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, q_push, !q_full)
    `PMFB_ASSERT_IMPLY(a_lit_pixel_is_accepted, clk, rst_n, result_valid && pixel, accepted)
    `PMFB_ASSERT_NEXT(a_no_result_after_clear, clk, rst_n, clearing, !result_valid)

endmodule

`default_nettype wire
